// ----- hdl/lsse_pkg.sv -----
// ----------------------------------------------------------------------------
// lsse_pkg: shared definitions for the LED strip SPI symbol encoder
// Field widths, action and register codes, reset values and the control
// struct passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package lsse_pkg;

    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 5;
    localparam int COLOUR_W    = 24;
    localparam int SYM_W       = 8;
    localparam int WORD_W      = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int SEL_W       = 2;
    localparam int GAP_CNT_W   = 2;

    localparam int PIXELS_DEF      = 16;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int GAP_WORDS       = 3;

    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FILL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GAP  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_SYMBOL  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_SYMBOL = 2'd1;

    localparam logic [SYM_W-1:0] ONE_SYMBOL_RST  = 8'h7c;
    localparam logic [SYM_W-1:0] ZERO_SYMBOL_RST = 8'h70;

    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd0;
    localparam logic [SEL_W-1:0] SEL_RED   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic             load;
        logic             gap;
        logic             last;
        logic             fill;
        logic [SEL_W-1:0] sel;
    } t_emit;

endpackage

// ----- hdl/lsse_store.sv -----
// ----------------------------------------------------------------------------
// lsse_store: pixel frame store
// One 24-bit colour per pixel, cleared by reset, one write port and one
// asynchronous read port addressed by the sequencer.
// ----------------------------------------------------------------------------
module lsse_store #(
    parameter int PIXELS = lsse_pkg::PIXELS_DEF,
    parameter int PIX_W  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [PIX_W-1:0]              i_waddr,
    input  logic [lsse_pkg::COLOUR_W-1:0] i_wdata,
    input  logic [PIX_W-1:0]              i_raddr,
    output logic [lsse_pkg::COLOUR_W-1:0] o_rdata
);

    logic [lsse_pkg::COLOUR_W-1:0] r_mem [PIXELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIXELS; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

// ----- hdl/lsse_symbol_unit.sv -----
// ----------------------------------------------------------------------------
// lsse_symbol_unit: shared byte to symbol word encoder
// Expands one data byte into eight SPI symbol bytes, MSB first, or gives a
// zero word for a gap, and holds the word in the output register until it is taken.
// ----------------------------------------------------------------------------
module lsse_symbol_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsse_pkg::t_emit              i_emit,
    input  logic [7:0]                   i_byte,
    input  logic [lsse_pkg::SYM_W-1:0]   i_one_symbol,
    input  logic [lsse_pkg::SYM_W-1:0]   i_zero_symbol,
    output logic                         o_stall,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lsse_pkg::WORD_W-1:0]  o_coded_word,
    output logic                         o_gap_word,
    output logic                         o_last
);

    logic                        r_valid;
    logic [lsse_pkg::WORD_W-1:0] r_word;
    logic                        r_gap;
    logic                        r_last;
    logic [lsse_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = '0;
        for (int k = 0; k < 8; k++) begin
            n_word[lsse_pkg::WORD_W-1-lsse_pkg::SYM_W*k -: lsse_pkg::SYM_W] =
                i_byte[7-k] ? i_one_symbol : i_zero_symbol;
        end
        if (i_emit.gap) begin
            n_word = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_word <= n_word;
            r_gap  <= i_emit.gap;
            r_last <= i_emit.last;
        end
    end

    assign o_stall      = r_valid && !i_ready;
    assign o_valid      = r_valid;
    assign o_coded_word = r_word;
    assign o_gap_word   = r_gap;
    assign o_last       = r_last;

endmodule

// ----- hdl/lsse_seq.sv -----
// ----------------------------------------------------------------------------
// lsse_seq: refresh sequencer
// Takes one request, walks pixels and colour bytes for a set or fill, then
// the latch gap, issuing one encoder load per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lsse_seq #(
    parameter int PIXELS = lsse_pkg::PIXELS_DEF,
    parameter int PIX_W  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lsse_pkg::ACTION_W-1:0] i_action,
    input  logic                          i_stall,
    output lsse_pkg::t_emit               o_emit,
    output logic [PIX_W-1:0]              o_pix
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PIX  = 2'd1;
    localparam logic [1:0] ST_GAP  = 2'd2;

    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXELS - 1);
    localparam logic [lsse_pkg::GAP_CNT_W-1:0] GAP_LAST =
        lsse_pkg::GAP_CNT_W'(lsse_pkg::GAP_WORDS - 1);

    logic [1:0]                        r_state, n_state;
    logic [PIX_W-1:0]                  r_pix, n_pix;
    logic [lsse_pkg::SEL_W-1:0]        r_sel, n_sel;
    logic [lsse_pkg::GAP_CNT_W-1:0]    r_gcnt, n_gcnt;
    logic                              r_fill, n_fill;
    logic                              advance;

    assign advance = !i_stall;

    always_comb begin
        n_state = r_state;
        n_pix   = r_pix;
        n_sel   = r_sel;
        n_gcnt  = r_gcnt;
        n_fill  = r_fill;
        o_emit  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_pix  = '0;
                    n_sel  = lsse_pkg::SEL_GREEN;
                    n_gcnt = '0;
                    n_fill = (i_action == lsse_pkg::ACT_FILL);
                    case (i_action)
                        lsse_pkg::ACT_SET:  n_state = ST_PIX;
                        lsse_pkg::ACT_FILL: n_state = ST_PIX;
                        lsse_pkg::ACT_GAP:  n_state = ST_GAP;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIX: begin
                o_emit.load = advance;
                o_emit.sel  = r_sel;
                o_emit.fill = r_fill;
                if (advance) begin
                    if (r_sel == lsse_pkg::SEL_BLUE) begin
                        n_sel = lsse_pkg::SEL_GREEN;
                        if (r_pix == PIX_LAST) begin
                            n_pix   = '0;
                            n_state = ST_GAP;
                        end else begin
                            n_pix = r_pix + 1'b1;
                        end
                    end else begin
                        n_sel = r_sel + 1'b1;
                    end
                end
            end
            ST_GAP: begin
                o_emit.load = advance;
                o_emit.gap  = 1'b1;
                o_emit.last = (r_gcnt == GAP_LAST);
                if (advance) begin
                    if (r_gcnt == GAP_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_gcnt = r_gcnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pix   <= '0;
            r_sel   <= lsse_pkg::SEL_GREEN;
            r_gcnt  <= '0;
            r_fill  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pix   <= n_pix;
            r_sel   <= n_sel;
            r_gcnt  <= n_gcnt;
            r_fill  <= n_fill;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_pix   = r_pix;

endmodule

// ----- hdl/led_strip_spi_symbol_encoder.sv -----
// ----------------------------------------------------------------------------
// led_strip_spi_symbol_encoder: SPI symbol stream for a one-wire LED strip
// Keeps a frame of PIXELS colours and streams it as packed SPI symbol words.
// ----------------------------------------------------------------------------
// A set-pixel or fill request is followed by 3*PIXELS colour words (green,
// red, blue per pixel, MSB first) and three zero latch-gap words; a gap-only
// request gives the three gap words; action 3 is dropped. The encoder issues
// one word per cycle while the output is not stalled, and keeps the input
// not ready from the accepted request until the last gap word is loaded.
// The next request is taken while the final word waits at the output.
// Symbol registers are written at any time through the config port.
module led_strip_spi_symbol_encoder #(
    parameter int PIXELS = lsse_pkg::PIXELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lsse_pkg::ACTION_W-1:0]    i_action,
    input  logic [lsse_pkg::INDEX_W-1:0]     i_pixel_index,
    input  logic [lsse_pkg::COLOUR_W-1:0]    i_colour,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lsse_pkg::WORD_W-1:0]      o_coded_word,
    output logic                             o_gap_word,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsse_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsse_pkg::SYM_W-1:0]       i_cfg_data
);

    localparam int PIX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    logic [lsse_pkg::SYM_W-1:0]    r_one_symbol;
    logic [lsse_pkg::SYM_W-1:0]    r_zero_symbol;
    logic [lsse_pkg::COLOUR_W-1:0] r_colour;
    logic                          accept;
    logic                          store_we;
    logic [PIX_W-1:0]              pix;
    logic [lsse_pkg::COLOUR_W-1:0] store_rd;
    logic [lsse_pkg::COLOUR_W-1:0] src;
    logic [7:0]                    byte_sel;
    logic                          stall;
    lsse_pkg::t_emit               emit;

    assign accept   = i_valid && o_ready;
    assign store_we = accept && (i_action == lsse_pkg::ACT_SET) &&
                      ({1'b0, i_pixel_index} < (lsse_pkg::INDEX_W + 1)'(PIXELS));

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_symbol  <= lsse_pkg::ONE_SYMBOL_RST;
            r_zero_symbol <= lsse_pkg::ZERO_SYMBOL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lsse_pkg::CFG_ONE_SYMBOL:  r_one_symbol  <= i_cfg_data;
                lsse_pkg::CFG_ZERO_SYMBOL: r_zero_symbol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_colour <= i_colour;
        end
    end

    lsse_seq #(
        .PIXELS (PIXELS),
        .PIX_W  (PIX_W)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_stall  (stall),
        .o_emit   (emit),
        .o_pix    (pix)
    );

    lsse_store #(
        .PIXELS (PIXELS),
        .PIX_W  (PIX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (store_we),
        .i_waddr (i_pixel_index[PIX_W-1:0]),
        .i_wdata (i_colour),
        .i_raddr (pix),
        .o_rdata (store_rd)
    );

    assign src = emit.fill ? r_colour : store_rd;

    always_comb begin
        case (emit.sel)
            lsse_pkg::SEL_GREEN: byte_sel = src[15:8];
            lsse_pkg::SEL_RED:   byte_sel = src[23:16];
            lsse_pkg::SEL_BLUE:  byte_sel = src[7:0];
            default:             byte_sel = src[7:0];
        endcase
    end

    lsse_symbol_unit u_symbol (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_emit        (emit),
        .i_byte        (byte_sel),
        .i_one_symbol  (r_one_symbol),
        .i_zero_symbol (r_zero_symbol),
        .o_stall       (stall),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_coded_word  (o_coded_word),
        .o_gap_word    (o_gap_word),
        .o_last        (o_last)
    );

endmodule

// ----- dv/lsse_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsse_frame_checker: output checker for the LED strip SPI symbol encoder
// Watches the request, result and symbol register channels, keeps its own
// copy of the frame store and symbol registers, expands each accepted
// request into the coded words it must produce, and compares every
// accepted result word field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module lsse_frame_checker #(
    parameter int PIXELS = lsse_pkg::PIXELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [lsse_pkg::ACTION_W-1:0]    i_action,
    input  logic [lsse_pkg::INDEX_W-1:0]     i_pixel_index,
    input  logic [lsse_pkg::COLOUR_W-1:0]    i_colour,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [lsse_pkg::WORD_W-1:0]      i_coded_word,
    input  logic                             i_gap_word,
    input  logic                             i_last,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [lsse_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsse_pkg::SYM_W-1:0]       i_cfg_data,
    output int                               o_error_count,
    output int                               o_words_pending
);

    localparam int PIX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    typedef struct packed {
        logic [lsse_pkg::WORD_W-1:0] word;
        logic                        gap;
        logic                        last;
    } t_coded_word;

    logic [lsse_pkg::COLOUR_W-1:0] frame_colour [PIXELS];
    logic [lsse_pkg::SYM_W-1:0]    one_sym;
    logic [lsse_pkg::SYM_W-1:0]    zero_sym;
    t_coded_word                   pending_words [$];
    int                            error_count;

    function automatic logic [lsse_pkg::WORD_W-1:0] spi_symbols_of_byte(
        input logic [7:0] value);
        logic [lsse_pkg::WORD_W-1:0] word;
        word = '0;
        for (int k = 7; k >= 0; k--) begin
            word = {word[lsse_pkg::WORD_W-lsse_pkg::SYM_W-1:0],
                    (value[k] ? one_sym : zero_sym)};
        end
        return word;
    endfunction

    task automatic queue_pixel_words(input logic [lsse_pkg::COLOUR_W-1:0] rgb);
        pending_words.push_back('{word: spi_symbols_of_byte(rgb[15:8]), gap: 1'b0,
                                  last: 1'b0});
        pending_words.push_back('{word: spi_symbols_of_byte(rgb[23:16]), gap: 1'b0,
                                  last: 1'b0});
        pending_words.push_back('{word: spi_symbols_of_byte(rgb[7:0]), gap: 1'b0,
                                  last: 1'b0});
    endtask

    task automatic predict_frame_words(input logic [lsse_pkg::ACTION_W-1:0] action,
                                       input logic [lsse_pkg::INDEX_W-1:0]  index,
                                       input logic [lsse_pkg::COLOUR_W-1:0] rgb);
        if (action == lsse_pkg::ACT_SET && index < PIXELS) begin
            frame_colour[index[PIX_W-1:0]] = rgb;
        end
        if (action == lsse_pkg::ACT_SET || action == lsse_pkg::ACT_FILL) begin
            for (int p = 0; p < PIXELS; p++) begin
                queue_pixel_words(action == lsse_pkg::ACT_SET ? frame_colour[p] : rgb);
            end
        end
        if (action == lsse_pkg::ACT_SET || action == lsse_pkg::ACT_FILL ||
            action == lsse_pkg::ACT_GAP) begin
            for (int g = 0; g < lsse_pkg::GAP_WORDS; g++) begin
                pending_words.push_back('{word: '0, gap: 1'b1,
                                          last: (g == lsse_pkg::GAP_WORDS - 1)});
            end
        end
    endtask

    task automatic report_field(input string field,
                                input logic [lsse_pkg::WORD_W-1:0] exp_val,
                                input logic [lsse_pkg::WORD_W-1:0] got_val);
        error_count++;
        $error("%s mismatch: expected %h, actual %h", field, exp_val, got_val);
    endtask

    task automatic check_coded_word();
        t_coded_word exp_word;
        if (pending_words.size() == 0) begin
            error_count++;
            $error("coded_word with nothing expected: actual %h", i_coded_word);
        end else begin
            exp_word = pending_words.pop_front();
            if (i_coded_word !== exp_word.word) begin
                report_field("coded_word", exp_word.word, i_coded_word);
            end
            if (i_gap_word !== exp_word.gap) begin
                report_field("gap_word", {{(lsse_pkg::WORD_W-1){1'b0}}, exp_word.gap},
                             {{(lsse_pkg::WORD_W-1){1'b0}}, i_gap_word});
            end
            if (i_last !== exp_word.last) begin
                report_field("last", {{(lsse_pkg::WORD_W-1){1'b0}}, exp_word.last},
                             {{(lsse_pkg::WORD_W-1){1'b0}}, i_last});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PIXELS; p++) begin
                frame_colour[p] = '0;
            end
            one_sym  = lsse_pkg::ONE_SYMBOL_RST;
            zero_sym = lsse_pkg::ZERO_SYMBOL_RST;
            pending_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lsse_pkg::CFG_ONE_SYMBOL: begin
                        one_sym = i_cfg_data;
                    end
                    lsse_pkg::CFG_ZERO_SYMBOL: begin
                        zero_sym = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_frame_words(i_action, i_pixel_index, i_colour);
            end
            if (i_out_valid && i_out_ready) begin
                check_coded_word();
            end
        end
        o_error_count   <= error_count;
        o_words_pending <= pending_words.size();
    end

endmodule

// ----- dv/tb_led_strip_spi_symbol_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_strip_spi_symbol_encoder: stimulus and verdict for the encoder
// Drives set-pixel, fill, gap-only and unused requests with random gaps,
// stalls the result side at random (with one long hold-off that backs up
// the request side), rewrites both symbol registers between phases while
// the encoder is idle, and reports the checker's outcome at the end.
// ----------------------------------------------------------------------------
module tb_led_strip_spi_symbol_encoder;

    localparam logic [lsse_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 64;
    localparam int ITEMS_PER_PHASE = 44;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_valid       = 1'b0;
    logic                             o_ready;
    logic [lsse_pkg::ACTION_W-1:0]    i_action      = '0;
    logic [lsse_pkg::INDEX_W-1:0]     i_pixel_index = '0;
    logic [lsse_pkg::COLOUR_W-1:0]    i_colour      = '0;
    logic                             o_valid;
    logic                             i_ready       = 1'b0;
    logic [lsse_pkg::WORD_W-1:0]      o_coded_word;
    logic                             o_gap_word;
    logic                             o_last;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic [lsse_pkg::CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [lsse_pkg::SYM_W-1:0]       i_cfg_data    = '0;

    int error_count;
    int words_pending;
    int long_holds_asked = 0;
    bit sender_pauses    = 1'b1;

    led_strip_spi_symbol_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_pixel_index (i_pixel_index),
        .i_colour      (i_colour),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_coded_word  (o_coded_word),
        .o_gap_word    (o_gap_word),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lsse_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_action        (i_action),
        .i_pixel_index   (i_pixel_index),
        .i_colour        (i_colour),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_coded_word    (o_coded_word),
        .i_gap_word      (o_gap_word),
        .i_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_count),
        .o_words_pending (words_pending)
    );

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    initial begin
        #40_000_000;
        $display("tb_led_strip_spi_symbol_encoder: errors");
        $finish;
    end

    function automatic int idle_cycles();
        if ($urandom_range(0, 19) < 16) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // result side: calm and stalling stretches, plus the long hold-off on demand
    initial begin
        int  served;
        int  hold_left;
        int  stall_left;
        int  stretch_left;
        bit  calm;
        served       = 0;
        hold_left    = 0;
        stall_left   = 0;
        stretch_left = 0;
        calm         = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_holds_asked != served) begin
                served++;
                hold_left = LONG_HOLD;
            end
            if (stretch_left == 0) begin
                calm         = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(40, 300);
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = idle_cycles() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [lsse_pkg::ACTION_W-1:0] action,
                                input logic [lsse_pkg::INDEX_W-1:0]  index,
                                input logic [lsse_pkg::COLOUR_W-1:0] rgb);
        i_valid       <= 1'b1;
        i_action      <= action;
        i_pixel_index <= index;
        i_colour      <= rgb;
        do @(posedge i_clk); while (!o_ready);
        if (sender_pauses && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat (idle_cycles()) @(posedge i_clk);
        end
    endtask

    task automatic send_random_requests(input int count);
        int                            sent;
        int                            pick;
        logic [lsse_pkg::ACTION_W-1:0] action;
        logic [lsse_pkg::INDEX_W-1:0]  index;
        logic [lsse_pkg::COLOUR_W-1:0] rgb;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                action = lsse_pkg::ACT_SET;
            end else if (pick < 75) begin
                action = lsse_pkg::ACT_FILL;
            end else if (pick < 88) begin
                action = lsse_pkg::ACT_GAP;
            end else begin
                action = ACT_UNUSED;
            end
            if ($urandom_range(0, 9) == 0) begin
                index = 5'($urandom_range(lsse_pkg::PIXELS_DEF, 31));
            end else begin
                index = 5'($urandom_range(0, lsse_pkg::PIXELS_DEF - 1));
            end
            pick = $urandom_range(0, 9);
            rgb  = (pick == 0) ? '1 : (pick == 1) ? '0 : 24'($urandom());
            send_request(action, index, rgb);
            if (action != ACT_UNUSED) begin
                sent++;
            end
        end
    endtask

    // hold until every expected word is out, then let the encoder settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_symbols(input logic [lsse_pkg::SYM_W-1:0] one_sym,
                                 input logic [lsse_pkg::SYM_W-1:0] zero_sym);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= lsse_pkg::CFG_ONE_SYMBOL;
        i_cfg_data  <= one_sym;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= lsse_pkg::CFG_ZERO_SYMBOL;
        i_cfg_data  <= zero_sym;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(lsse_pkg::ACT_GAP, 5'd0, 24'h000000);
        send_request(lsse_pkg::ACT_FILL, 5'd31, 24'h000000);
        send_request(lsse_pkg::ACT_FILL, 5'd0, 24'hffffff);
        send_request(lsse_pkg::ACT_FILL, 5'd21, 24'ha55ac3);
        send_request(lsse_pkg::ACT_SET, 5'd0, 24'hffffff);
        send_request(lsse_pkg::ACT_SET, 5'd15, 24'h123456);
        send_request(lsse_pkg::ACT_SET, 5'd16, 24'habcdef);
        send_request(lsse_pkg::ACT_SET, 5'd31, 24'hffffff);
        send_request(lsse_pkg::ACT_SET, 5'd7, 24'h000000);
        send_request(ACT_UNUSED, 5'd31, 24'hffffff);
        send_request(ACT_UNUSED, 5'd0, 24'h000000);
        send_request(lsse_pkg::ACT_SET, 5'd0, 24'h000000);
        send_request(lsse_pkg::ACT_GAP, 5'd31, 24'hffffff);
        wait_idle();

        write_symbols(8'hff, 8'h00);
        send_request(lsse_pkg::ACT_FILL, 5'd10, 24'h5a5a5a);
        send_request(lsse_pkg::ACT_SET, 5'd8, 24'hf0f00f);
        send_request(lsse_pkg::ACT_GAP, 5'd3, 24'h00ff00);
        send_random_requests(ITEMS_PER_PHASE - 3);
        wait_idle();

        // back up the request side behind a long result hold-off
        write_symbols(8'h00, 8'hff);
        sender_pauses = 1'b0;
        long_holds_asked <= long_holds_asked + 1;
        send_random_requests(8);
        sender_pauses = 1'b1;
        send_random_requests(ITEMS_PER_PHASE - 8);
        wait_idle();

        write_symbols(8'($urandom()), 8'($urandom()));
        sender_pauses = 1'b0;
        send_random_requests(ITEMS_PER_PHASE);
        sender_pauses = 1'b1;
        wait_idle();

        write_symbols(8'($urandom()), 8'($urandom()));
        send_random_requests(ITEMS_PER_PHASE);
        wait_idle();

        write_symbols(lsse_pkg::ONE_SYMBOL_RST, lsse_pkg::ZERO_SYMBOL_RST);
        send_random_requests(ITEMS_PER_PHASE);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_led_strip_spi_symbol_encoder: clean");
        end else begin
            $display("tb_led_strip_spi_symbol_encoder: errors");
        end
        $finish;
    end

endmodule
